@@ rtl/pfb_pkg.sv @@
// shared types, codes and defaults for the page-mode frame buffer
package pfb_pkg;

	localparam int DEF_SCREEN_WIDTH  = 128;
	localparam int DEF_SCREEN_HEIGHT = 64;
	localparam int GLYPH_COLS        = 5;
	localparam int GLYPH_ADVANCE     = 6;

	typedef enum logic [2:0] {
		ACT_SET_PIX    = 3'd0,
		ACT_CLR_PIX    = 3'd1,
		ACT_CLEAR_ALL  = 3'd2,
		ACT_SET_CURSOR = 3'd3,
		ACT_PRINT      = 3'd4,
		ACT_READ       = 3'd5
	} pfb_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PIX_WR,
		ST_GLYPH,
		ST_RD_OUT
	} pfb_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic set_cursor;
		logic pix_wr;
		logic glyph_wr;
		logic clr_wr;
		logic rd_out;
	} pfb_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic parked;
		logic sweep_last;
		logic glyph_last;
	} pfb_sts_t;

endpackage

@@ rtl/page_frame_buffer_text_cursor.sv @@
// top level of the page-mode frame buffer with text cursor
//
// a transaction is taken at a rising edge with start high and busy low. set and
// clear pixel do a read then a write on the single-port image ram; a byte read
// shows its byte on read_data with read_valid high for a single cycle, the
// cycle after acceptance, with no way to hold it off; the cursor is placed at
// acceptance; printing a glyph makes 5 column writes through the ram's one
// port, and the glyph is dropped when the cursor is parked; clear-all writes
// one byte per cycle over the whole image. after reset the block runs the same
// clearing pass with busy high. action codes 6 and 7 do nothing.
module page_frame_buffer_text_cursor
	import pfb_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [7:0]  x,
	input  logic [7:0]  y,
	input  logic [39:0] glyph,
	input  logic [9:0]  read_index,
	output logic        read_valid,
	output logic [7:0]  read_data
);

	pfb_cmd_t cmd;
	pfb_sts_t sts;

	// sequencing: one transaction at a time
	pfb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// image ram, cursor registers and address arithmetic
	pfb_dpath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (action),
		.x          (x),
		.y          (y),
		.glyph      (glyph),
		.read_index (read_index),
		.sts        (sts),
		.read_data  (read_data)
	);

	// result strobe straight from the controller
	assign read_valid = cmd.rd_out;

	// a result only follows an accepted read
	assert property (@(posedge clk) disable iff (!arst_n)
		read_valid |-> $past(start && !busy && action == ACT_READ))
		else $error("read result without a read transaction");

	// the ram's single port never sees two write sources at once
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.glyph_wr, cmd.pix_wr}))
		else $error("conflicting image writes");

	// clear-all keeps the block busy while it sweeps
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_CLEAR_ALL) |=> (busy && cmd.clr_wr))
		else $error("clear-all did not start the sweep");

endmodule

@@ rtl/pfb_ctrl.sv @@
// controller state machine for the page-mode frame buffer
module pfb_ctrl
	import pfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] action,
	input  pfb_sts_t   sts,
	output logic       busy,
	output pfb_cmd_t   cmd
);

	pfb_state_t state_q;
	pfb_state_t state_d;

	// reset enters the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_SET_PIX,
						ACT_CLR_PIX:   state_d = ST_PIX_WR;
						ACT_CLEAR_ALL: state_d = ST_CLEAR;
						ACT_PRINT:     state_d = sts.parked ? ST_IDLE : ST_GLYPH;
						ACT_READ:      state_d = ST_RD_OUT;
						default:       state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_PIX_WR: state_d = ST_IDLE;
			ST_GLYPH: begin
				if (sts.glyph_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD_OUT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy           = 1'b0;
				cmd.accept     = start;
				cmd.set_cursor = start && (action == ACT_SET_CURSOR);
			end
			ST_CLEAR:  cmd.clr_wr   = 1'b1;
			ST_PIX_WR: cmd.pix_wr   = 1'b1;
			ST_GLYPH:  cmd.glyph_wr = 1'b1;
			ST_RD_OUT: cmd.rd_out   = 1'b1;
			default:   busy         = 1'b1;
		endcase
	end

endmodule

@@ rtl/pfb_dpath.sv @@
// datapath for the page-mode frame buffer: image ram, cursor and address logic
module pfb_dpath
	import pfb_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pfb_cmd_t    cmd,
	input  logic [2:0]  action,
	input  logic [7:0]  x,
	input  logic [7:0]  y,
	input  logic [39:0] glyph,
	input  logic [9:0]  read_index,
	output pfb_sts_t    sts,
	output logic [7:0]  read_data
);

	localparam int PAGE_COUNT  = SCREEN_HEIGHT / 8;
	localparam int IMAGE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int MAX_COL     = SCREEN_WIDTH - 5;
	localparam int MAX_ROW     = SCREEN_HEIGHT - 8;
	localparam int AW          = $clog2(IMAGE_BYTES);
	localparam int LW          = $clog2(SCREEN_WIDTH) + 6;
	localparam int CW          = (LW > 11) ? LW : 11;
	localparam int CLW         = $clog2(SCREEN_WIDTH + 2);
	localparam int RW          = $clog2(SCREEN_HEIGHT + 1);
	localparam int GW          = $clog2(GLYPH_COLS);

	logic [7:0]     mem [IMAGE_BYTES];
	logic [7:0]     rdata_q;

	logic [CLW-1:0] col_q;
	logic [RW-1:0]  row_q;
	logic [AW-1:0]  sweep_q;
	logic [GW-1:0]  gcnt_q;

	logic [AW-1:0]  idx_q;
	logic [2:0]     bit_q;
	logic           set_q;
	logic           pix_ok_q;
	logic           rd_ok_q;
	logic [AW-1:0]  base_q;
	logic [39:0]    glyph_q;

	logic [LW-1:0]  pix_idx;
	logic           pix_ok;
	logic           rd_ok;
	logic [AW-1:0]  port_addr;
	logic [AW-1:0]  base;
	logic [7:0]     bit_mask;
	logic [7:0]     pix_data;
	logic           mem_we;
	logic [AW-1:0]  mem_addr;
	logic [7:0]     mem_wdata;
	logic [CLW-1:0] col_adv;
	logic [RW-1:0]  row_adv;
	logic [CLW-1:0] col_set;
	logic [RW-1:0]  row_set;

	// address of a pixel byte and range checks straight from the inputs
	assign pix_idx = LW'(x) + LW'(y[7:3]) * LW'(SCREEN_WIDTH);
	assign pix_ok  = ({1'b0, x} < 9'(SCREEN_WIDTH)) && ({1'b0, y} < 9'(SCREEN_HEIGHT))
		&& (CW'(pix_idx) < CW'(IMAGE_BYTES));
	assign rd_ok   = CW'(read_index) < CW'(IMAGE_BYTES);
	assign port_addr = (action == ACT_READ) ? AW'(read_index) : AW'(pix_idx);

	assign base = AW'(col_q) + AW'(row_q[RW-1:3]) * AW'(SCREEN_WIDTH);

	assign sts.parked     = col_q > CLW'(MAX_COL);
	assign sts.sweep_last = sweep_q == AW'(IMAGE_BYTES - 1);
	assign sts.glyph_last = gcnt_q == GW'(GLYPH_COLS - 1);

	// single-port image ram
	assign bit_mask = 8'(1) << bit_q;
	assign pix_data = set_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = port_addr;
		mem_wdata = '0;
		priority if (cmd.clr_wr) begin
			mem_we   = 1'b1;
			mem_addr = sweep_q;
		end else if (cmd.glyph_wr) begin
			mem_we    = 1'b1;
			mem_addr  = base_q;
			mem_wdata = glyph_q[7:0];
		end else if (cmd.pix_wr) begin
			mem_we    = pix_ok_q;
			mem_addr  = idx_q;
			mem_wdata = pix_data;
		end else begin
			mem_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr];
	end

	// transaction capture and glyph column walk
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q    <= AW'(pix_idx);
			bit_q    <= y[2:0];
			set_q    <= action == ACT_SET_PIX;
			pix_ok_q <= pix_ok;
			rd_ok_q  <= rd_ok;
			base_q   <= base;
			glyph_q  <= glyph;
		end else if (cmd.glyph_wr) begin
			base_q  <= base_q + AW'(1);
			glyph_q <= glyph_q >> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			gcnt_q  <= '0;
		end else begin
			if (cmd.clr_wr) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + AW'(1);
			end
			if (cmd.glyph_wr) begin
				gcnt_q <= sts.glyph_last ? '0 : gcnt_q + GW'(1);
			end
		end
	end

	// cursor placement with clamp
	assign col_set = ({1'b0, x} > 9'(MAX_COL)) ? CLW'(MAX_COL) : CLW'(x);
	assign row_set = ({1'b0, y} > 9'(MAX_ROW)) ? RW'(MAX_ROW) : RW'(y);

	// cursor advance after a glyph: wrap to next page or park past the end
	always_comb begin
		col_adv = col_q + CLW'(GLYPH_ADVANCE);
		row_adv = row_q;
		if (col_adv > CLW'(MAX_COL)) begin
			if (row_q >= RW'(MAX_ROW)) begin
				col_adv = CLW'(SCREEN_WIDTH);
				row_adv = RW'(MAX_ROW);
			end else begin
				col_adv = '0;
				row_adv = row_q + RW'(8);
				if (row_adv > RW'(MAX_ROW)) begin
					row_adv = RW'(MAX_ROW);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.set_cursor) begin
			col_q <= col_set;
			row_q <= row_set;
		end else if (cmd.glyph_wr && sts.glyph_last) begin
			col_q <= col_adv;
			row_q <= row_adv;
		end
	end

	assign read_data = rd_ok_q ? rdata_q : '0;

endmodule
